FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on a rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LSB payload extractor.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int DEF_EXT_LEN_BITS = 32;
    localparam int DEF_SIZE_BITS    = 32;

    localparam int PASS_W     = 64;
    localparam int PASS_LEN_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic
    {
        REG_PASS_CHARS = 1'b0,
        REG_PASS_LEN   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        KIND_EXT_CHAR = 2'd0,
        KIND_PAYLOAD  = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_EMPTY    = 2'd3
    } kind_t;

    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef struct packed
    {
        logic main_valid;
        logic skid_valid;
    } buf_status_t;

endpackage

FILE: src/lse_cfg_regs.sv
// ----------------------------------------------------------------------------
// lse_cfg_regs
// APB register file holding the passcode characters and passcode length.
// ----------------------------------------------------------------------------
module lse_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lse_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lse_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lse_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [lse_pkg::PASS_W-1:0]        passcode_chars,
    output logic [lse_pkg::PASS_LEN_W-1:0]    passcode_len
);
    import lse_pkg::*;

    logic [PASS_W-1:0]     pass_chars_reg;
    logic [PASS_LEN_W-1:0] pass_len_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign idx    = reg_idx_t'(paddr[3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_chars_reg <= '0;
            pass_len_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (idx == REG_PASS_CHARS)
            begin
                pass_chars_reg <= pwdata[PASS_W-1:0];
            end
            else
            begin
                pass_len_reg <= pwdata[PASS_LEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_PASS_CHARS: prdata = pass_chars_reg;
            REG_PASS_LEN:   prdata = {{(CFG_DATA_W-PASS_LEN_W){1'b0}}, pass_len_reg};
            default:        prdata = '0;
        endcase
    end

    assign passcode_chars = pass_chars_reg;
    assign passcode_len   = pass_len_reg;

endmodule

FILE: src/lse_decoder.sv
// ----------------------------------------------------------------------------
// lse_decoder
// Header parse, LSB gathering and frame sequencing; one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module lse_decoder
#(
    parameter int EXT_LEN_BITS = lse_pkg::DEF_EXT_LEN_BITS,
    parameter int SIZE_BITS    = lse_pkg::DEF_SIZE_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            start_req,
    input  logic [7:0]                      image_byte,
    input  logic [lse_pkg::PASS_W-1:0]      passcode_chars,
    input  logic [lse_pkg::PASS_LEN_W-1:0]  passcode_len,
    output logic                            push,
    output lse_pkg::result_t                push_data
);
    import lse_pkg::*;

    localparam int SHIFT_W = (EXT_LEN_BITS > SIZE_BITS) ? EXT_LEN_BITS : SIZE_BITS;
    localparam int BC_W    = $clog2(SHIFT_W);
    localparam int NEED_W  = BC_W + 1;
    localparam int CHAR_W  = 8;
    localparam int MAX_PASS = 8;
    localparam logic [7:0]  MARK_CHAR = 8'h2A;
    localparam logic [31:0] HDR_END   = 32'd14;
    localparam logic [31:0] OFS_FIRST = 32'd10;
    localparam logic [31:0] OFS_LAST  = 32'd13;

    typedef enum logic [2:0]
    {
        PH_HEADER,
        PH_PASS,
        PH_MARKER,
        PH_EXTLEN,
        PH_EXTCHR,
        PH_SIZE,
        PH_DATA,
        PH_IDLE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         ofs_reg, ofs_next;
    logic [BC_W-1:0]     bc_reg, bc_next;
    logic [SHIFT_W-1:0]  sh_reg, sh_next;
    logic [3:0]          ci_reg, ci_next;
    logic [SHIFT_W-1:0]  rc_reg, rc_next;
    logic [3:0]          pass_limit;

    assign pass_limit = (passcode_len > PASS_LEN_W'(MAX_PASS))
                        ? PASS_LEN_W'(MAX_PASS) : passcode_len;

    always_comb
    begin
        logic               go;
        logic [SHIFT_W-1:0] sh_new;
        logic [NEED_W-1:0]  needed;
        logic [7:0]         ch;
        logic [7:0]         pass_ch;

        phase_next = start_req ? PH_HEADER : phase_reg;
        pos_next   = start_req ? '0 : pos_reg;
        ofs_next   = start_req ? '0 : ofs_reg;
        bc_next    = start_req ? '0 : bc_reg;
        sh_next    = start_req ? '0 : sh_reg;
        ci_next    = start_req ? '0 : ci_reg;
        rc_next    = start_req ? '0 : rc_reg;
        push       = 1'b0;
        push_data  = '{kind: KIND_EXT_CHAR, out_byte: 8'h00, last: 1'b0};
        go         = 1'b0;
        sh_new     = '0;
        needed     = NEED_W'(CHAR_W);
        ch         = 8'h00;
        pass_ch    = 8'h00;

        if (phase_next != PH_IDLE)
        begin
            go = 1'b1;
            if (phase_next == PH_HEADER)
            begin
                if (pos_next >= HDR_END && pos_next >= ofs_next)
                begin
                    phase_next = (pass_limit == '0) ? PH_MARKER : PH_PASS;
                    ci_next    = '0;
                    bc_next    = '0;
                    sh_next    = '0;
                end
                else
                begin
                    go = 1'b0;
                    if (pos_next inside {[OFS_FIRST:OFS_LAST]})
                    begin
                        case (pos_next[1:0])
                            2'b10:   ofs_next[7:0]   = ofs_next[7:0]   | image_byte;
                            2'b11:   ofs_next[15:8]  = ofs_next[15:8]  | image_byte;
                            2'b00:   ofs_next[23:16] = ofs_next[23:16] | image_byte;
                            default: ofs_next[31:24] = ofs_next[31:24] | image_byte;
                        endcase
                    end
                    if (pos_next != '1)
                    begin
                        pos_next = pos_next + 32'd1;
                    end
                end
            end

            if (go)
            begin
                sh_new = {sh_next[SHIFT_W-2:0], image_byte[0]};
                ch     = sh_new[7:0];
                case (phase_next)
                    PH_EXTLEN: needed = NEED_W'(EXT_LEN_BITS);
                    PH_SIZE:   needed = NEED_W'(SIZE_BITS);
                    default:   needed = NEED_W'(CHAR_W);
                endcase

                if ({1'b0, bc_next} + NEED_W'(1) < needed)
                begin
                    bc_next = bc_next + BC_W'(1);
                    sh_next = sh_new;
                end
                else
                begin
                    bc_next = '0;
                    sh_next = '0;
                    case (phase_next)
                        PH_PASS:
                        begin
                            pass_ch = passcode_chars[8*ci_next[2:0] +: 8];
                            if (ch != pass_ch)
                            begin
                                phase_next = PH_IDLE;
                                push       = 1'b1;
                                push_data  = '{kind: KIND_MISMATCH, out_byte: 8'h00,
                                               last: 1'b1};
                            end
                            else
                            begin
                                ci_next = ci_next + 4'd1;
                                if (ci_next >= pass_limit)
                                begin
                                    phase_next = PH_MARKER;
                                end
                            end
                        end
                        PH_MARKER:
                        begin
                            if (ch != MARK_CHAR)
                            begin
                                phase_next = PH_IDLE;
                                push       = 1'b1;
                                push_data  = '{kind: KIND_MISMATCH, out_byte: 8'h00,
                                               last: 1'b1};
                            end
                            else
                            begin
                                phase_next = PH_EXTLEN;
                            end
                        end
                        PH_EXTLEN:
                        begin
                            rc_next    = sh_new;
                            phase_next = (sh_new == '0) ? PH_SIZE : PH_EXTCHR;
                        end
                        PH_EXTCHR:
                        begin
                            rc_next = rc_next - SHIFT_W'(1);
                            if (rc_next == '0)
                            begin
                                phase_next = PH_SIZE;
                            end
                            push      = 1'b1;
                            push_data = '{kind: KIND_EXT_CHAR, out_byte: ch, last: 1'b0};
                        end
                        PH_SIZE:
                        begin
                            rc_next = sh_new;
                            if (sh_new == '0)
                            begin
                                phase_next = PH_IDLE;
                                push       = 1'b1;
                                push_data  = '{kind: KIND_EMPTY, out_byte: 8'h00,
                                               last: 1'b1};
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            rc_next   = rc_next - SHIFT_W'(1);
                            push      = 1'b1;
                            push_data = '{kind: KIND_PAYLOAD, out_byte: ch,
                                          last: (rc_next == '0)};
                            if (rc_next == '0)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end

        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            ofs_reg   <= '0;
            bc_reg    <= '0;
            sh_reg    <= '0;
            ci_reg    <= '0;
            rc_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ofs_reg   <= ofs_next;
            bc_reg    <= bc_next;
            sh_reg    <= sh_next;
            ci_reg    <= ci_next;
            rc_reg    <= rc_next;
        end
    end

endmodule

FILE: src/lse_out_buf.sv
// ----------------------------------------------------------------------------
// lse_out_buf
// Result register with one skid entry between decoder and result channel.
// ----------------------------------------------------------------------------
module lse_out_buf
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lse_pkg::result_t      push_data,
    output logic                  full,
    output logic                  res_valid,
    input  logic                  res_stall,
    output lse_pkg::result_t      res_data,
    output lse_pkg::buf_status_t  status
);
    import lse_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop = main_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign res_valid = main_valid_reg;
    assign res_data  = main_reg;
    assign status    = '{main_valid: main_valid_reg, skid_valid: skid_valid_reg};

endmodule

FILE: src/lsb_stego_payload_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor
// Recovers a hidden extension and payload from the LSBs of a BMP byte stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one file byte per request, with
// start_req high on the first byte of a file. Bytes 10 to 13 give the pixel
// offset; LSBs from that offset on form the passcode, the '*' marker, the
// extension length and characters, the payload length and payload bytes.
// Result channel (res_valid/res_stall) carries kind, out_byte and last.
// A request is taken every cycle while in_stall is low and goes through a
// single decoder register stage; a byte that completes an output character, a
// mismatch or a zero payload length registers its result in the result register
// or, while that is held, in the skid entry, so a new request enters while a
// result waits. in_stall rises only when both result entries are held by res_stall.
// Reset puts the decoder in the header phase at byte zero and clears both
// passcode registers; bytes sent before any start are parsed as a file.
// Configuration uses APB at byte addresses 0 (passcode_chars) and 8 (passcode_len);
// the user must write them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsb_stego_payload_extractor
#(
    parameter int EXT_LEN_BITS = lse_pkg::DEF_EXT_LEN_BITS,
    parameter int SIZE_BITS    = lse_pkg::DEF_SIZE_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lse_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [lse_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [lse_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            start_req,
    input  logic [7:0]                      image_byte,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [1:0]                      kind,
    output logic [7:0]                      out_byte,
    output logic                            last
);
    import lse_pkg::*;

    logic [PASS_W-1:0]     passcode_chars;
    logic [PASS_LEN_W-1:0] passcode_len;
    logic                  accept;
    logic                  push;
    logic                  full;
    result_t               push_data;
    result_t               res_data;
    buf_status_t           status;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    lse_cfg_regs u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .passcode_chars (passcode_chars),
        .passcode_len   (passcode_len)
    );

    lse_decoder
    #(
        .EXT_LEN_BITS (EXT_LEN_BITS),
        .SIZE_BITS    (SIZE_BITS)
    )
    u_dec
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .start_req      (start_req),
        .image_byte     (image_byte),
        .passcode_chars (passcode_chars),
        .passcode_len   (passcode_len),
        .push           (push),
        .push_data      (push_data)
    );

    lse_out_buf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .status    (status)
    );

    assign kind     = res_data.kind;
    assign out_byte = res_data.out_byte;
    assign last     = res_data.last;

    `ASSERT_IMPLY(a_skid_needs_main, clk, rst_n, status.skid_valid, status.main_valid)
    `ASSERT_IMPLY(a_end_kinds_last, clk, rst_n, res_valid && (kind == KIND_MISMATCH || kind == KIND_EMPTY), last && out_byte == 8'h00)
    `ASSERT_NEXT(a_fill_skid, clk, rst_n, status.main_valid && res_stall && push && !status.skid_valid, status.skid_valid)
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, $past(res_valid && res_stall))

endmodule
